FILE: hdl/sprite_scanline_evaluator_assert.svh
// assertion macros shared by the checker files of the sprite scanline evaluator
// no dependencies; include by bare file name
`ifndef SPRITE_SCANLINE_EVALUATOR_ASSERT_SVH
`define SPRITE_SCANLINE_EVALUATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sse assertion failed");

// next-cycle implication, disabled while reset is low
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sse assertion failed");

`endif

FILE: hdl/sse_pkg.sv
// shared widths, codes, types and size table of the sprite scanline evaluator
// no dependencies
`default_nettype none

package sse_pkg;

    localparam int IDX_IN_W   = 7;
    localparam int Y_W        = 8;
    localparam int LINE_W     = 8;
    localparam int CNT_OUT_W  = 6;
    localparam int MODE_W     = 3;
    localparam int MAXL_W     = 6;
    localparam int SCNT_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int SHIFT_W    = 2;

    localparam int SPRITE_COUNT_DEF = 128;
    localparam int LINE_LIMIT_DEF   = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_LINE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_COUNT   = 2'd2;

    localparam logic [MODE_W-1:0] SIZE_MODE_RST    = 3'd0;
    localparam logic [MAXL_W-1:0] MAX_PER_LINE_RST = 6'd32;
    localparam logic [SCNT_W-1:0] SCAN_COUNT_RST   = 8'd128;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // height shift per size mode, {small, large}
    localparam logic [SHIFT_W-1:0] SIZE_SHIFT_TAB [8][2] = '{
        '{2'd0, 2'd1}, '{2'd0, 2'd2}, '{2'd0, 2'd3}, '{2'd1, 2'd2},
        '{2'd1, 2'd3}, '{2'd2, 2'd3}, '{2'd0, 2'd0}, '{2'd0, 2'd0}
    };

    typedef struct packed {
        logic [MODE_W-1:0] size_mode;
        logic [MAXL_W-1:0] max_per_line;
        logic [SCNT_W-1:0] scan_count;
    } t_cfg;

    typedef struct packed {
        logic           big;
        logic [Y_W-1:0] top;
    } t_entry;

    typedef struct packed {
        logic [IDX_IN_W-1:0]  hit_index;
        logic                 hit;
        logic [CNT_OUT_W-1:0] hit_count;
        logic                 last;
    } t_result;

    // true when the sprite starting at top covers line
    function automatic logic covers(input logic [LINE_W-1:0] line, input logic [Y_W-1:0] top,
                                    input logic [MODE_W-1:0] mode, input logic big);
        logic [SHIFT_W-1:0] shift;
        logic [LINE_W-1:0]  gap;
        logic [LINE_W-1:0]  height;
        shift  = SIZE_SHIFT_TAB[mode][big];
        gap    = line - top;
        height = 8'd8 << shift;
        return gap < height;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sse_table.sv
// sprite table: one-write one-read synchronous memory with per-entry valid bits
// depends on sse_pkg
`default_nettype none

module sse_table #(
    parameter int SPRITE_COUNT = sse_pkg::SPRITE_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [sse_pkg::IDX_IN_W-1:0]  i_wr_idx,
    input  wire sse_pkg::t_entry               i_wr_entry,
    input  wire logic                          i_rd_en,
    input  wire logic [$clog2(SPRITE_COUNT)-1:0] i_rd_idx,
    output sse_pkg::t_entry                    o_rd_entry
);

    localparam int IDX_W = $clog2(SPRITE_COUNT);
    localparam logic [sse_pkg::IDX_IN_W:0] SC_EXT = (sse_pkg::IDX_IN_W + 1)'(SPRITE_COUNT);

    sse_pkg::t_entry         r_mem [SPRITE_COUNT];
    sse_pkg::t_entry         r_rd_data;
    logic [SPRITE_COUNT-1:0] r_valid;
    logic                    r_rd_ok;
    logic                    wr_ok;
    logic [IDX_W-1:0]        wr_addr;

    // writes beyond the table are dropped
    assign wr_ok   = i_wr_en && ({1'b0, i_wr_idx} < SC_EXT);
    assign wr_addr = i_wr_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_rd_idx];
            end
        end
    end

    // never-written entries read as zero
    assign o_rd_entry = r_rd_ok ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: hdl/sse_scan.sv
// scan sequencer: walks the sprite table, tests each entry, holds one pending hit
// and drives the result register; depends on sse_pkg
`default_nettype none

module sse_scan #(
    parameter int SPRITE_COUNT = sse_pkg::SPRITE_COUNT_DEF,
    parameter int LINE_LIMIT   = sse_pkg::LINE_LIMIT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_opcode,
    input  wire logic [sse_pkg::LINE_W-1:0]      i_scan_line,
    input  wire logic [sse_pkg::IDX_IN_W-1:0]    i_first_sprite,
    input  wire sse_pkg::t_cfg                   i_cfg,
    output logic                                 o_rd_en,
    output logic [$clog2(SPRITE_COUNT)-1:0]      o_rd_idx,
    input  wire sse_pkg::t_entry                 i_rd_entry,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output sse_pkg::t_result                     o_result
);

    localparam int IDX_W  = $clog2(SPRITE_COUNT);
    localparam int LEFT_W = $clog2(SPRITE_COUNT + 1);
    localparam int HIT_W  = $clog2(LINE_LIMIT + 1);

    localparam logic [sse_pkg::IDX_IN_W:0]   SC_START = (sse_pkg::IDX_IN_W + 1)'(SPRITE_COUNT);
    localparam logic [sse_pkg::IDX_IN_W-1:0] SC_SUB   = sse_pkg::IDX_IN_W'(SPRITE_COUNT);
    localparam logic [sse_pkg::SCNT_W-1:0]   SC_CNT   = sse_pkg::SCNT_W'(SPRITE_COUNT);
    localparam logic [IDX_W-1:0]             IDX_LAST = IDX_W'(SPRITE_COUNT - 1);
    localparam logic [sse_pkg::MAXL_W:0]     LL_EXT   = (sse_pkg::MAXL_W + 1)'(LINE_LIMIT);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REDUCE = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    logic [1:0]                      r_state;
    logic [sse_pkg::LINE_W-1:0]      r_line;
    logic [sse_pkg::IDX_IN_W-1:0]    r_start;
    logic [IDX_W-1:0]                r_rd_idx;
    logic [LEFT_W-1:0]               r_left;
    logic [HIT_W-1:0]                r_limit;
    logic [HIT_W-1:0]                r_hits;
    logic                            r_b_vld;
    logic [IDX_W-1:0]                r_b_idx;
    logic                            r_p_vld;
    logic [IDX_W-1:0]                r_p_idx;
    logic [HIT_W-1:0]                r_p_cnt;
    logic                            r_o_vld;
    sse_pkg::t_result                r_o;

    logic                            hit_now;
    logic                            out_free;
    logic                            b_block;
    logic [HIT_W-1:0]                hits_inc;
    logic                            limit_reached;
    logic                            issue;
    logic                            push_mid;
    logic                            push_fin;
    logic                            eval_acc;
    logic                            reduce_more;
    logic [sse_pkg::MAXL_W:0]        lim_ext;
    logic [sse_pkg::MAXL_W:0]        lim_sat;
    logic [sse_pkg::SCNT_W-1:0]      cnt_sat;
    sse_pkg::t_result                n_o;

    assign eval_acc = (r_state == ST_IDLE) && i_valid && (i_opcode == sse_pkg::OP_EVAL);

    // per-evaluation limits
    assign lim_ext = {1'b0, (i_cfg.max_per_line == '0) ? sse_pkg::MAXL_W'(1) : i_cfg.max_per_line};
    assign lim_sat = (lim_ext > LL_EXT) ? LL_EXT : lim_ext;
    assign cnt_sat = (i_cfg.scan_count > SC_CNT) ? SC_CNT : i_cfg.scan_count;

    assign reduce_more = ({1'b0, r_start} >= SC_START);

    // test stage on the registered entry of the latest table read
    assign hit_now = r_b_vld && sse_pkg::covers(r_line, i_rd_entry.top, i_cfg.size_mode,
                                                i_rd_entry.big);
    assign out_free      = !r_o_vld || !i_stall;
    assign b_block       = hit_now && r_p_vld && !out_free;
    assign hits_inc      = r_hits + 1'b1;
    assign limit_reached = hit_now && (hits_inc >= r_limit);
    assign issue = (r_state == ST_SCAN) && !b_block && !limit_reached && (r_left != '0);

    assign push_mid = (r_state == ST_SCAN) && hit_now && r_p_vld && out_free;
    assign push_fin = (r_state == ST_FLUSH) && out_free;

    assign o_rd_en  = issue;
    assign o_rd_idx = r_rd_idx;
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_o_vld;
    assign o_result = r_o;

    always_comb begin
        n_o.hit_index = sse_pkg::IDX_IN_W'(r_p_idx);
        n_o.hit       = 1'b1;
        n_o.hit_count = sse_pkg::CNT_OUT_W'(r_p_cnt);
        n_o.last      = push_fin;
        if (push_fin && !r_p_vld) begin
            n_o.hit_index = '0;
            n_o.hit       = 1'b0;
            n_o.hit_count = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_b_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (push_mid || push_fin) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (eval_acc) begin
                        r_b_vld <= 1'b0;
                        r_p_vld <= 1'b0;
                        r_state <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if (!reduce_more) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (!b_block) begin
                        r_b_vld <= issue;
                        if (hit_now) begin
                            r_p_vld <= 1'b1;
                        end
                        if (limit_reached || (r_left == '0)) begin
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        r_p_vld <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (push_mid || push_fin) begin
            r_o <= n_o;
        end
        case (r_state)
            ST_IDLE: begin
                if (eval_acc) begin
                    r_line  <= i_scan_line;
                    r_start <= i_first_sprite;
                    r_limit <= HIT_W'(lim_sat);
                    r_left  <= LEFT_W'(cnt_sat);
                    r_hits  <= '0;
                end
            end
            ST_REDUCE: begin
                if (reduce_more) begin
                    r_start <= r_start - SC_SUB;
                end else begin
                    r_rd_idx <= r_start[IDX_W-1:0];
                end
            end
            ST_SCAN: begin
                if (!b_block) begin
                    r_b_idx <= r_rd_idx;
                    if (issue) begin
                        r_rd_idx <= (r_rd_idx == IDX_LAST) ? '0 : r_rd_idx + 1'b1;
                        r_left   <= r_left - 1'b1;
                    end
                    if (hit_now) begin
                        r_hits  <= hits_inc;
                        r_p_idx <= r_b_idx;
                        r_p_cnt <= hits_inc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/sprite_scanline_evaluator.sv
// top level of the sprite scanline evaluator: configuration registers, sprite
// table and scan sequencer; depends on sse_pkg, sse_table, sse_scan
//   input channel (i_valid / o_stall): a write item (opcode write) stores one
//   sprite's top line (y byte plus one) and size bit and gives no result. an
//   evaluate item tests one scanline against the table.
//   output channel (o_valid / i_stall): one item per hit, in scan order, with a
//   running hit count; the final item of an evaluation has o_last set. when no
//   sprite covers the line a single item with o_hit low is given.
//   busy period: an evaluation holds o_stall high until its final item is
//   registered, longer for each time first_sprite must be folded back below
//   SPRITE_COUNT and for any receiver stall. the table memory is read once per
//   cycle while the scan is not blocked; that single read port sets the pace.
//   a hit is not given out when the scan reaches it, since each hit is held
//   until the next one or the end of the scan decides its last flag.
//   receiver stall: the result register holds its item; the scan goes on until
//   a new hit meets a held pending hit, then waits. a finished final item may
//   still wait in the register while the next input item is accepted.
//   reset: registers return to size mode 0, 32 per line, 128 scanned; all table
//   entries read as zero until written (per-entry valid bits, no clearing pass).
//   configuration writes are taken on any cycle with i_cfg_we high.
`default_nettype none

module sprite_scanline_evaluator #(
    parameter int SPRITE_COUNT = sse_pkg::SPRITE_COUNT_DEF,
    parameter int LINE_LIMIT   = sse_pkg::LINE_LIMIT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [sse_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sse_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input items
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_opcode,
    input  wire logic [sse_pkg::IDX_IN_W-1:0]      i_sprite_index,
    input  wire logic [sse_pkg::Y_W-1:0]           i_y_byte,
    input  wire logic                              i_size_bit,
    input  wire logic [sse_pkg::LINE_W-1:0]        i_scan_line,
    input  wire logic [sse_pkg::IDX_IN_W-1:0]      i_first_sprite,
    // result items
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [sse_pkg::IDX_IN_W-1:0]           o_hit_index,
    output logic                                   o_hit,
    output logic [sse_pkg::CNT_OUT_W-1:0]          o_hit_count,
    output logic                                   o_last
);

    localparam int IDX_W = $clog2(SPRITE_COUNT);

    sse_pkg::t_cfg    r_cfg;
    sse_pkg::t_entry  wr_entry;
    sse_pkg::t_entry  rd_entry;
    sse_pkg::t_result result;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;

    // configuration registers, low bits of the data word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_mode    <= sse_pkg::SIZE_MODE_RST;
            r_cfg.max_per_line <= sse_pkg::MAX_PER_LINE_RST;
            r_cfg.scan_count   <= sse_pkg::SCAN_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sse_pkg::CFG_SIZE_MODE: begin
                    r_cfg.size_mode <= i_cfg_data[sse_pkg::MODE_W-1:0];
                end
                sse_pkg::CFG_MAX_PER_LINE: begin
                    r_cfg.max_per_line <= i_cfg_data[sse_pkg::MAXL_W-1:0];
                end
                sse_pkg::CFG_SCAN_COUNT: begin
                    r_cfg.scan_count <= i_cfg_data[sse_pkg::SCNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // a write item goes straight into the table at its accept edge
    assign wr_en        = i_valid && !o_stall && (i_opcode == sse_pkg::OP_WRITE);
    assign wr_entry.top = i_y_byte + 8'd1;
    assign wr_entry.big = i_size_bit;

    sse_table #(
        .SPRITE_COUNT (SPRITE_COUNT)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_idx   (i_sprite_index),
        .i_wr_entry (wr_entry),
        .i_rd_en    (rd_en),
        .i_rd_idx   (rd_idx),
        .o_rd_entry (rd_entry)
    );

    sse_scan #(
        .SPRITE_COUNT (SPRITE_COUNT),
        .LINE_LIMIT   (LINE_LIMIT)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_scan_line    (i_scan_line),
        .i_first_sprite (i_first_sprite),
        .i_cfg          (r_cfg),
        .o_rd_en        (rd_en),
        .o_rd_idx       (rd_idx),
        .i_rd_entry     (rd_entry),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result       (result)
    );

    assign o_hit_index = result.hit_index;
    assign o_hit       = result.hit;
    assign o_hit_count = result.hit_count;
    assign o_last      = result.last;

endmodule

`default_nettype wire

FILE: hdl/sse_checker.sv
// port-level checks of the sprite scanline evaluator, bound to its top level
// depends on sse_pkg and sprite_scanline_evaluator_assert.svh
`default_nettype none

`include "sprite_scanline_evaluator_assert.svh"

module sse_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_stall,
    input wire logic                           i_opcode,
    input wire logic                           o_valid,
    input wire logic                           i_stall,
    input wire logic [sse_pkg::IDX_IN_W-1:0]   o_hit_index,
    input wire logic                           o_hit,
    input wire logic [sse_pkg::CNT_OUT_W-1:0]  o_hit_count,
    input wire logic                           o_last
);

    // held result keeps its payload
    `SSE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_hit_index) && $stable(o_hit) && $stable(o_hit_count) && $stable(o_last))

    // the no-hit item is a single final item of zeros
    `SSE_ASSERT_NOW(a_nohit, i_clk, i_rst_n, o_valid && !o_hit, o_last && (o_hit_count == '0) && (o_hit_index == '0))

    // only the final item of an evaluation can be a miss
    `SSE_ASSERT_NOW(a_mid_hit, i_clk, i_rst_n, o_valid && !o_last, o_hit)

    // a hit always carries a nonzero running count
    `SSE_ASSERT_NOW(a_hit_cnt, i_clk, i_rst_n, o_valid && o_hit, o_hit_count != '0)

    // an accepted evaluation blocks the input side in the next cycle
    `SSE_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, i_valid && !o_stall && (i_opcode == sse_pkg::OP_EVAL), o_stall)

endmodule

bind sprite_scanline_evaluator sse_checker u_sse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_opcode    (i_opcode),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_hit_index (o_hit_index),
    .o_hit       (o_hit),
    .o_hit_count (o_hit_count),
    .o_last      (o_last)
);

`default_nettype wire
